/* rtl/hfr_pkg.sv */
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared types, constants and the CRC-16/KERMIT byte fold for the HDLC
// frame receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

  // Frame position and message length width (covers up to 64 + 1 bytes)
  localparam int CNT_W     = 7;
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 6;
  localparam int CRC_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Bytes that precede the CRC check and trailing CRC bytes
  localparam logic [CNT_W-1:0] HEADER_BYTES = CNT_W'(4);
  localparam logic [CNT_W-1:0] CRC_BYTES    = CNT_W'(2);

  // Reflected polynomial 0x1021
  localparam logic [CRC_W-1:0] KERMIT_POLY = 16'h8408;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAG_BYTE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;
  localparam logic [BYTE_W-1:0] MASK_RESET   = 8'h20;

  // Request from the deframer to replay a validated message
  typedef struct packed {
    logic             go;
    logic [CNT_W-1:0] len;
  } hfr_launch_t;

  // Fold one byte into a CRC-16/KERMIT value, one bit per step
  function automatic logic [CRC_W-1:0] kermit_fold(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ KERMIT_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/hfr_ram.sv */
// ----------------------------------------------------------------------------
// hfr_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module hfr_ram #(
  parameter int W          = 8,
  parameter int DEPTH      = 65,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hfr_deframe.sv */
// ----------------------------------------------------------------------------
// hfr_deframe
// Configuration registers, flag/escape handling, frame store writes,
// running CRC and the CRC match that launches a message replay.
// ----------------------------------------------------------------------------
module hfr_deframe #(
  parameter int MAX_FRAME_BYTES = 64,
  localparam int AW             = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [hfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [hfr_pkg::BYTE_W-1:0]    mem_wdata,
  output hfr_pkg::hfr_launch_t          launch
);
  import hfr_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  logic [BYTE_W-1:0] flag_r, esc_r, mask_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              esc_pend_r, esc_pend_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic [BYTE_W-1:0] last1_r, last1_nxt;
  logic [BYTE_W-1:0] last2_r, last2_nxt;

  logic              accept;
  logic [BYTE_W-1:0] data_byte;
  logic [CNT_W-1:0]  held;
  logic [CRC_W-1:0]  crc_fold;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= FLAG_RESET;
      esc_r  <= ESCAPE_RESET;
      mask_r <= MASK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLAG_BYTE:   flag_r <= cfg_wdata;
        CFG_ESCAPE_BYTE: esc_r  <= cfg_wdata;
        CFG_INVERT_MASK: mask_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept    = in_valid && !in_stall;
  assign data_byte = esc_pend_r ? (in_rx_byte ^ mask_r) : in_rx_byte;
  assign held      = count_r + CNT_W'(1);
  // Fold the byte that just dropped behind the two CRC bytes
  assign crc_fold  = (held > CRC_BYTES) ? kermit_fold(crc_r, last2_r) : crc_r;

  // Classify the beat, store data bytes and check the trailing CRC
  always_comb begin
    count_nxt    = count_r;
    esc_pend_nxt = esc_pend_r;
    crc_nxt      = crc_r;
    last1_nxt    = last1_r;
    last2_nxt    = last2_r;
    mem_we       = 1'b0;
    mem_waddr    = count_r[AW-1:0];
    mem_wdata    = data_byte;
    launch.go    = 1'b0;
    launch.len   = held - CRC_BYTES;
    if (accept) begin
      priority if (in_rx_byte == flag_r) begin
        count_nxt    = '0;
        esc_pend_nxt = 1'b0;
        crc_nxt      = '0;
      end else if (in_rx_byte == esc_r) begin
        esc_pend_nxt = 1'b1;
      end else begin
        mem_we       = 1'b1;
        esc_pend_nxt = 1'b0;
        last1_nxt    = data_byte;
        last2_nxt    = last1_r;
        launch.go    = (held >= HEADER_BYTES) && ({data_byte, last1_r} == crc_fold);
        if (held > MAX_CNT) begin
          count_nxt = '0;
          crc_nxt   = '0;
        end else begin
          count_nxt = held;
          crc_nxt   = crc_fold;
        end
      end
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      esc_pend_r <= 1'b0;
      crc_r      <= '0;
    end else begin
      count_r    <= count_nxt;
      esc_pend_r <= esc_pend_nxt;
      crc_r      <= crc_nxt;
    end
  end

  // Last two stored bytes
  always_ff @(posedge clk) begin
    last1_r <= last1_nxt;
    last2_r <= last2_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("frame position past maximum");
  a_launch_len: assert property (@(posedge clk) disable iff (!rst_n)
    launch.go |-> (mem_we && launch.len >= CRC_BYTES))
    else $error("replay launched without a stored byte or too short");
  a_flag_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_rx_byte == flag_r) |=> (count_r == '0 && !esc_pend_r && crc_r == '0))
    else $error("flag beat did not restart the frame");
`endif

endmodule

/* rtl/hfr_replay.sv */
// ----------------------------------------------------------------------------
// hfr_replay
// Reads a validated message back out of the frame store, one byte per
// cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module hfr_replay #(
  parameter int MAX_FRAME_BYTES = 64,
  localparam int AW             = $clog2(MAX_FRAME_BYTES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hfr_pkg::hfr_launch_t       launch,
  output logic                       busy,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [hfr_pkg::BYTE_W-1:0] mem_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hfr_pkg::BYTE_W-1:0] out_msg_byte,
  output logic [hfr_pkg::IDX_W-1:0]  out_byte_index,
  output logic                       out_last
);
  import hfr_pkg::*;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0] pend_idx_r;
  logic             pend_last_r;
  logic             out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;

  logic load;
  logic issue;

  // Move read data into the output register when it is empty or draining
  assign load  = rd_pend_r && (!out_valid_r || !out_stall);
  // Issue the next read when its data slot will be free
  assign issue = busy_r && (rd_addr_r != len_r) && (!rd_pend_r || load);

  assign mem_re    = issue;
  assign mem_raddr = rd_addr_r[AW-1:0];

  // Read sequencer next state
  always_comb begin
    rd_pend_nxt   = issue || (rd_pend_r && !load);
    rd_addr_nxt   = issue ? (rd_addr_r + CNT_W'(1)) : rd_addr_r;
    len_nxt       = len_r;
    busy_nxt      = busy_r && !((rd_addr_nxt == len_r) && !rd_pend_nxt);
    out_valid_nxt = load || (out_valid_r && out_stall);
    if (launch.go) begin
      busy_nxt    = 1'b1;
      rd_addr_nxt = '0;
      len_nxt     = launch.len;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rd_addr_r   <= '0;
      len_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rd_addr_r   <= rd_addr_nxt;
      len_r       <= len_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Tag the pending read and capture the output beat
  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r  <= rd_addr_r[IDX_W-1:0];
      pend_last_r <= (rd_addr_r + CNT_W'(1)) == len_r;
    end
    if (load) begin
      out_byte_r <= mem_rdata;
      out_idx_r  <= pend_idx_r;
      out_last_r <= pend_last_r;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_msg_byte   = out_byte_r;
  assign out_byte_index = out_idx_r;
  assign out_last       = out_last_r;

`ifndef ASSERT_OFF
  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    launch.go |=> busy_r)
    else $error("launch did not start replay");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !rd_pend_r)
    else $error("read pending after replay ended");
  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rd_addr_r <= len_r)
    else $error("read address past message length");
  a_no_relaunch: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !launch.go)
    else $error("launch while replay in progress");
`endif

endmodule

/* rtl/hdlc_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_top
// Byte-stuffed HDLC-style frame receiver with CRC-16/KERMIT check and
// message replay from an on-chip frame store.
// ----------------------------------------------------------------------------
// Takes one raw link byte per cycle while not stalled. Flag, escape and
// ordinary bytes are handled in the cycle they are accepted; ordinary bytes
// are written to the frame store RAM. When a byte completes a frame whose
// last two bytes equal the CRC-16/KERMIT of the bytes before them (low byte
// first), input stalls while the message of N bytes (frame length minus two)
// is read back through the RAM's single registered read port at one byte per
// cycle when the output does not stall; the last message beat may still wait
// in the output register while input resumes. No clearing pass after reset.
module hdlc_frame_receiver_top #(
  parameter int MAX_FRAME_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hfr_pkg::BYTE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hfr_pkg::BYTE_W-1:0]    out_msg_byte,
  output logic [hfr_pkg::IDX_W-1:0]     out_byte_index,
  output logic                          out_last
);
  import hfr_pkg::*;

  localparam int DEPTH = MAX_FRAME_BYTES + 1;
  localparam int AW    = $clog2(DEPTH);

  hfr_launch_t       launch;
  logic              busy;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  // Hold input while a message is being replayed
  assign in_stall = busy;

  hfr_deframe #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .launch    (launch)
  );

  hfr_ram #(
    .W    (BYTE_W),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  hfr_replay #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_replay (
    .clk           (clk),
    .rst_n         (rst_n),
    .launch        (launch),
    .busy          (busy),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_msg_byte  (out_msg_byte),
    .out_byte_index(out_byte_index),
    .out_last      (out_last)
  );

endmodule

/* dv/hdlc_frame_receiver_top_tb.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_top_tb
// Self-checking bench for the HDLC frame receiver. Drives byte-stuffed frames,
// broken frames and link noise under several flag/escape/mask settings. An
// in-bench deframer with its own CRC-16/KERMIT predicts every replayed message
// beat, and each output beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hfr_pkg::*;

  localparam int STORE_DEPTH = 65;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [BYTE_W-1:0] msg_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;
  } msg_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_msg_byte;
  logic [IDX_W-1:0]     out_byte_index;
  logic                 out_last;

  // Deframer shadow state
  logic [BYTE_W-1:0] flag_r;
  logic [BYTE_W-1:0] esc_r;
  logic [BYTE_W-1:0] mask_r;
  logic [BYTE_W-1:0] held_bytes [0:STORE_DEPTH-1];
  int                held_count;
  logic              mark_set;
  logic [CRC_W-1:0]  body_crc;

  msg_beat_t         replay_q [$];
  logic [BYTE_W-1:0] msg_buf [$];
  int                error_count;
  int                bytes_sent;
  int                quiet_cycles;
  bit                quiet;

  hdlc_frame_receiver_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_msg_byte   (out_msg_byte),
    .out_byte_index (out_byte_index),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-16/KERMIT, reflected, one input bit per step
  function automatic logic [CRC_W-1:0] kermit_update(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = c[0] ^ b[k];
      c = c >> 1;
      if (fb) begin
        c = c ^ KERMIT_POLY;
      end
    end
    return c;
  endfunction

  function automatic void restart_shadow();
    held_count = 0;
    mark_set = 1'b0;
    body_crc = '0;
  endfunction

  // Advance the shadow deframer by one link byte and queue any replayed message
  function automatic void predict_rx_byte(input logic [BYTE_W-1:0] raw);
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  got;
    msg_beat_t         beat;
    int                len;
    b = raw;
    if (b == flag_r) begin
      restart_shadow();
      return;
    end
    if (b == esc_r) begin
      mark_set = 1'b1;
      return;
    end
    if (mark_set) begin
      b = b ^ mask_r;
      mark_set = 1'b0;
    end
    held_bytes[held_count] = b;
    held_count++;
    if (held_count > 2) begin
      body_crc = kermit_update(body_crc, held_bytes[held_count-3]);
    end
    if (held_count >= 4) begin
      got = {held_bytes[held_count-1], held_bytes[held_count-2]};
      if (got == body_crc) begin
        len = held_count - 2;
        for (int i = 0; i < len; i++) begin
          beat.msg_byte = held_bytes[i];
          beat.byte_index = IDX_W'(i);
          beat.last = (i == len - 1);
          replay_q.push_back(beat);
        end
      end
    end
    if (held_count > 64) begin
      restart_shadow();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Check each replayed beat against the oldest prediction
  always @(posedge clk) begin
    msg_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replay_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h idx=%0d last=%0b",
                                  out_msg_byte, out_byte_index, out_last));
      end else begin
        want = replay_q.pop_front();
        if (out_msg_byte !== want.msg_byte) begin
          report_mismatch($sformatf("msg_byte %02h, want %02h (idx %0d)",
                                    out_msg_byte, want.msg_byte, want.byte_index));
        end
        if (out_byte_index !== want.byte_index) begin
          report_mismatch($sformatf("byte_index %0d, want %0d",
                                    out_byte_index, want.byte_index));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %0b, want %0b (idx %0d)",
                                    out_last, want.last, want.byte_index));
        end
      end
    end
  end

  // Random receiver backpressure
  always @(posedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(99) < 13);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Send one link byte, sometimes idling one cycle first; valid stays high on return
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    predict_rx_byte(b);
    bytes_sent++;
  endtask

  // Drop valid and wait for every predicted beat plus the block's latency
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replay_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_FLAG_BYTE:   flag_r = v;
      CFG_ESCAPE_BYTE: esc_r = v;
      CFG_INVERT_MASK: mask_r = v;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_link(input logic [BYTE_W-1:0] f, input logic [BYTE_W-1:0] e,
                              input logic [BYTE_W-1:0] m);
    settle();
    write_reg(CFG_FLAG_BYTE, f);
    write_reg(CFG_ESCAPE_BYTE, e);
    write_reg(CFG_INVERT_MASK, m);
  endtask

  task automatic fill_msg(input int len);
    msg_buf.delete();
    for (int i = 0; i < len; i++) begin
      msg_buf.push_back(BYTE_W'($urandom_range(255)));
    end
  endtask

  // Escape any byte that collides with the flag or the escape code
  task automatic send_stuffed(input logic [BYTE_W-1:0] b);
    if (b == flag_r || b == esc_r) begin
      send_byte(esc_r);
      send_byte(b ^ mask_r);
    end else begin
      send_byte(b);
    end
  endtask

  // Frame msg_buf with its CRC, low byte first; corrupt flips one CRC bit
  task automatic send_frame(input bit open, input bit corrupt, input bit close);
    logic [CRC_W-1:0] crc;
    crc = '0;
    foreach (msg_buf[i]) crc = kermit_update(crc, msg_buf[i]);
    if (corrupt) begin
      crc = crc ^ (CRC_W'(1) << $urandom_range(CRC_W-1));
    end
    if (open) begin
      send_byte(flag_r);
    end
    foreach (msg_buf[i]) send_stuffed(msg_buf[i]);
    send_stuffed(crc[7:0]);
    send_stuffed(crc[15:8]);
    if (close) begin
      send_byte(flag_r);
    end
  endtask

  // Default link codes: shortest frame, extremes, stuffed flag and escape, bad CRC
  task automatic test_default_frames();
    msg_buf = '{8'h00, 8'hFF};
    send_frame(1, 0, 1);
    msg_buf = '{8'h7E, 8'h7D, 8'h00, 8'hFF, 8'h20, 8'h5E};
    send_frame(0, 0, 1);
    fill_msg(4);
    send_frame(0, 1, 1);
  endtask

  // Escape while marked, and a flag clearing a pending mark
  task automatic test_escape_cases();
    logic [CRC_W-1:0] crc;
    fill_msg(3);
    crc = '0;
    foreach (msg_buf[i]) crc = kermit_update(crc, msg_buf[i]);
    send_byte(flag_r);
    send_byte(esc_r);
    send_byte(esc_r);
    send_byte(msg_buf[0] ^ mask_r);
    send_stuffed(msg_buf[1]);
    send_stuffed(msg_buf[2]);
    send_stuffed(crc[7:0]);
    send_stuffed(crc[15:8]);
    send_byte(esc_r);
    send_byte(flag_r);
    fill_msg(2);
    send_frame(0, 0, 1);
  endtask

  // Largest frame, then restart after overflow
  task automatic test_long_frames();
    fill_msg(63);
    msg_buf[0] = 8'h7C;
    send_frame(1, 0, 0);
    fill_msg(2);
    send_frame(0, 0, 1);
    fill_msg(3);
    send_frame(0, 0, 1);
  endtask

  // Flag and escape codes equal: the flag meaning wins
  task automatic test_flag_is_escape();
    program_link(8'h55, 8'h55, 8'hAA);
    msg_buf = '{8'h55, 8'h12, 8'hAA};
    send_frame(1, 0, 1);
    fill_msg(3);
    send_frame(1, 0, 1);
    send_byte(8'h55);
    send_byte(8'h55);
  endtask

  // Extreme link codes, an all-zero mask, and the unused register slot
  task automatic test_extreme_config();
    program_link(8'h00, 8'hFF, 8'hFF);
    msg_buf = '{8'h00, 8'hFF, 8'h80};
    send_frame(1, 0, 1);
    program_link(8'hFF, 8'h00, 8'h00);
    msg_buf = '{8'h01, 8'hFE, 8'h00};
    send_frame(1, 0, 1);
    settle();
    write_reg(CFG_UNUSED, 8'hA5);
    fill_msg(4);
    send_frame(1, 0, 1);
    program_link(FLAG_RESET, ESCAPE_RESET, MASK_RESET);
  endtask

  // Full-rate frames with no idling on either side
  task automatic test_back_to_back();
    quiet = 1'b1;
    repeat (3) begin
      fill_msg($urandom_range(2, 8));
      send_frame(1, 0, 0);
    end
    send_byte(flag_r);
    quiet = 1'b0;
  endtask

  // Mostly well-formed frames with random content, mixed with noise, broken frames and link code changes
  task automatic test_random_traffic(input int target);
    int stop_at;
    int next_cfg;
    bit paused;
    int r;
    stop_at = bytes_sent + target;
    next_cfg = bytes_sent + 15;
    paused = 1'b0;
    while (bytes_sent < stop_at) begin
      if (bytes_sent >= next_cfg) begin
        next_cfg = bytes_sent + 15;
        if ($urandom_range(3) == 0) begin
          program_link(FLAG_RESET, ESCAPE_RESET, MASK_RESET);
        end else begin
          program_link(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                       BYTE_W'($urandom_range(255)));
        end
      end
      if (!paused && bytes_sent >= stop_at - target / 2) begin
        paused = 1'b1;
        settle();
      end
      r = $urandom_range(99);
      if (r < 70) begin
        fill_msg(($urandom_range(99) < 6) ? $urandom_range(32, 63) : $urandom_range(2, 10));
        send_frame(1, 0, $urandom_range(99) < 80);
      end else if (r < 80) begin
        fill_msg($urandom_range(2, 10));
        send_frame(1, 1, 1);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(255)));
      end else begin
        send_byte(flag_r);
        repeat ($urandom_range(1, 5)) send_byte(BYTE_W'($urandom_range(255)));
        send_byte(flag_r);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    out_stall <= 1'b0;
    quiet_cycles <= 0;
    quiet = 1'b0;
    error_count = 0;
    bytes_sent = 0;
    flag_r = FLAG_RESET;
    esc_r = ESCAPE_RESET;
    mask_r = MASK_RESET;
    restart_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_frames();
    test_escape_cases();
    test_long_frames();
    test_flag_is_escape();
    test_extreme_config();
    test_back_to_back();
    test_random_traffic(30);

    // Drain the last predictions, then let the pipeline go quiet
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
